[src/wbp_pkg.sv]
// ----------------------------------------------------------------------------
// wbp_pkg: shared types and constants for the wheel balance PID
// Field widths, fixed-point formats, register codes, queue entry and the
// request/response structs between the sequencer and the divider.
// ----------------------------------------------------------------------------
package wbp_pkg;

  // encoder count and integrator widths
  localparam int COUNT_WIDTH      = 32;
  localparam int INTEGRATOR_WIDTH = 40;

  // port field widths
  localparam int FIELD_W = 32;
  localparam int DT_W    = 20;
  localparam int ERR_W   = 16;
  localparam int DUTY_W  = 17;
  localparam int GAIN_W  = 16;
  localparam int SHIFT_W = 4;
  localparam int SCALE_W = 24;

  localparam int IN_W  = ((2 * FIELD_W + DT_W + 7) / 8) * 8;
  localparam int OUT_W = ((2 * DUTY_W + ERR_W + 7) / 8) * 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // fixed-point positions
  localparam int FRAC_W      = 8;
  localparam int SCALE_SHIFT = 24;

  localparam logic [DUTY_W-1:0] DUTY_MAX = DUTY_W'(65536);

  // register reset values
  localparam logic [GAIN_W-1:0]  KP_RST         = GAIN_W'(1536);
  localparam logic [GAIN_W-1:0]  KI_RST         = GAIN_W'(512);
  localparam logic [GAIN_W-1:0]  KD_RST         = GAIN_W'(5120);
  localparam logic [SHIFT_W-1:0] DECAY_RST      = SHIFT_W'(1);
  localparam logic [SCALE_W-1:0] SCALE_RST      = SCALE_W'(12945);
  localparam logic [DUTY_W-1:0]  LEFT_INIT_RST  = DUTY_W'(13107);
  localparam logic [DUTY_W-1:0]  RIGHT_INIT_RST = DUTY_W'(10486);

  // queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // shared multiplier and accumulator
  localparam int MA_W   = INTEGRATOR_WIDTH + 1;
  localparam int MB_W   = SCALE_W + 1;
  localparam int PROD_W = MA_W + MB_W;
  localparam int ACC_W  = INTEGRATOR_WIDTH + GAIN_W + 2;

  // derivative divider
  localparam int DMAG_W    = GAIN_W + ERR_W;
  localparam int DIV_N_W   = DMAG_W + FRAC_W;
  localparam int DIV_Q_W   = DIV_N_W + 1;
  localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

  // speed change limit and duty arithmetic
  localparam int DIFF_LOG = 20;
  localparam int DIFF_W   = DIFF_LOG + 2;
  localparam int SPD_W    = DIFF_W + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP         = 3'd0,
    REG_KI         = 3'd1,
    REG_KD         = 3'd2,
    REG_DECAY      = 3'd3,
    REG_SCALE      = 3'd4,
    REG_LEFT_INIT  = 3'd5,
    REG_RIGHT_INIT = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [GAIN_W-1:0]  kp;
    logic [GAIN_W-1:0]  ki;
    logic [GAIN_W-1:0]  kd;
    logic [SHIFT_W-1:0] decay;
    logic [SCALE_W-1:0] scale;
    logic [DUTY_W-1:0]  left_init;
    logic [DUTY_W-1:0]  right_init;
  } cfg_t;

  typedef struct packed {
    logic              prime;
    logic [ERR_W-1:0]  err;
    logic [DT_W-1:0]   dt;
  } q_entry_t;

  typedef struct packed {
    logic               start;
    logic               neg;
    logic [DIV_N_W-1:0] num;
    logic [DT_W-1:0]    den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_Q_W-1:0] quo;
  } div_rsp_t;

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_P    = 11'b000_0000_0010,
    S_I    = 11'b000_0000_0100,
    S_D    = 11'b000_0000_1000,
    S_DSET = 11'b000_0001_0000,
    S_DIV  = 11'b000_0010_0000,
    S_HI   = 11'b000_0100_0000,
    S_LO   = 11'b000_1000_0000,
    S_SUM  = 11'b001_0000_0000,
    S_DUTY = 11'b010_0000_0000,
    S_EMIT = 11'b100_0000_0000
  } back_state_e;

endpackage

[src/wbp_front.sv]
// ----------------------------------------------------------------------------
// wbp_front: tick intake
// Accepts encoder ticks, forms wrapped per-wheel deltas and the saturated
// error, marks the priming tick and pushes one entry per tick to the queue.
// ----------------------------------------------------------------------------
module wbp_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [wbp_pkg::IN_W-1:0]  s_axis_tdata,
  input  logic                      q_full,
  output logic                      q_push,
  output wbp_pkg::q_entry_t         q_entry
);

  localparam int CW = wbp_pkg::COUNT_WIDTH;
  localparam int EW = wbp_pkg::ERR_W;
  localparam logic signed [CW:0] E_MAX = (CW + 1)'(2 ** (EW - 1) - 1);
  localparam logic signed [CW:0] E_MIN = -(CW + 1)'(2 ** (EW - 1));

  logic [CW-1:0] last_left;
  logic [CW-1:0] last_right;
  logic          primed;

  logic [CW-1:0]           cur_left;
  logic [CW-1:0]           cur_right;
  logic [CW-1:0]           dl;
  logic [CW-1:0]           dr;
  logic signed [CW:0]      e_full;
  logic [EW-1:0]           e_sat;
  logic [wbp_pkg::DT_W-1:0] elapsed;

  assign s_axis_tready = !q_full;
  assign q_push        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    cur_left  = '0 - s_axis_tdata[CW-1:0];
    cur_right = s_axis_tdata[wbp_pkg::FIELD_W +: CW];
    elapsed   = s_axis_tdata[2 * wbp_pkg::FIELD_W +: wbp_pkg::DT_W];
    dl        = cur_left - last_left;
    dr        = cur_right - last_right;
    e_full    = $signed({dr[CW-1], dr}) - $signed({dl[CW-1], dl});
    if (e_full > E_MAX) begin
      e_sat = E_MAX[EW-1:0];
    end else if (e_full < E_MIN) begin
      e_sat = E_MIN[EW-1:0];
    end else begin
      e_sat = e_full[EW-1:0];
    end
    q_entry.prime = !primed;
    q_entry.err   = primed ? e_sat : '0;
    // zero elapsed time counts as one microsecond
    q_entry.dt    = (elapsed == '0) ? wbp_pkg::DT_W'(1) : elapsed;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_left  <= '0;
      last_right <= '0;
      primed     <= 1'b0;
    end else if (q_push) begin
      last_left  <= cur_left;
      last_right <= cur_right;
      primed     <= 1'b1;
    end
  end

endmodule

[src/wbp_fifo.sv]
// ----------------------------------------------------------------------------
// wbp_fifo: tick queue
// Short first-in first-out queue that decouples intake from the sequencer.
// ----------------------------------------------------------------------------
module wbp_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  wbp_pkg::q_entry_t wr_data,
  output logic              full,
  input  logic              pop,
  output wbp_pkg::q_entry_t rd_data,
  output logic              empty
);

  wbp_pkg::q_entry_t             mem [wbp_pkg::Q_DEPTH];
  logic [wbp_pkg::Q_AW-1:0]      wr_ptr;
  logic [wbp_pkg::Q_AW-1:0]      rd_ptr;
  logic [wbp_pkg::Q_CW-1:0]      count;

  localparam logic [wbp_pkg::Q_AW-1:0] LAST = wbp_pkg::Q_AW'(wbp_pkg::Q_DEPTH - 1);
  localparam logic [wbp_pkg::Q_CW-1:0] FULL_CNT = wbp_pkg::Q_CW'(wbp_pkg::Q_DEPTH);

  logic do_push;
  logic do_pop;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[src/wbp_div.sv]
// ----------------------------------------------------------------------------
// wbp_div: derivative divider
// Restoring divider, one quotient bit per cycle, on the magnitude of the
// derivative numerator; the sign is put back on the quotient (toward zero).
// ----------------------------------------------------------------------------
module wbp_div (
  input  logic              clk,
  input  logic              rst,
  input  wbp_pkg::div_req_t req,
  output wbp_pkg::div_rsp_t rsp
);

  localparam int NW = wbp_pkg::DIV_N_W;
  localparam int DW = wbp_pkg::DT_W;

  logic                          busy;
  logic                          done;
  logic [wbp_pkg::DIV_CNT_W-1:0] cnt;
  logic [NW-1:0]                 quo;
  logic [DW-1:0]                 rem;
  logic [DW-1:0]                 den;
  logic                          neg;

  logic [DW:0] rem_sh;
  logic        take;
  logic [DW:0] rem_sub;

  always_comb begin
    rem_sh  = {rem, quo[NW-1]};
    take    = (rem_sh >= {1'b0, den});
    rem_sub = rem_sh - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= wbp_pkg::DIV_CNT_W'(NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == wbp_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.num;
      rem <= '0;
      den <= req.den;
      neg <= req.neg;
    end else if (busy) begin
      quo <= {quo[NW-2:0], take};
      rem <= take ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = neg ? ('0 - {1'b0, quo}) : {1'b0, quo};

endmodule

[src/wbp_back.sv]
// ----------------------------------------------------------------------------
// wbp_back: PID sequencer
// Pops queued ticks, runs P, leaky I and D through one shared multiplier and
// the divider, scales the correction, updates both duties or loads the inits.
// ----------------------------------------------------------------------------
module wbp_back (
  input  logic                        clk,
  input  logic                        rst,
  input  wbp_pkg::cfg_t               cfg,
  input  logic                        q_empty,
  input  wbp_pkg::q_entry_t           q_data,
  output logic                        q_pop,
  output wbp_pkg::div_req_t           div_req,
  input  wbp_pkg::div_rsp_t           div_rsp,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [wbp_pkg::DUTY_W-1:0]  out_left,
  output logic [wbp_pkg::DUTY_W-1:0]  out_right,
  output logic [wbp_pkg::ERR_W-1:0]   out_err
);

  localparam int IW  = wbp_pkg::INTEGRATOR_WIDTH;
  localparam int EW  = wbp_pkg::ERR_W;
  localparam int GW  = wbp_pkg::GAIN_W;
  localparam int AW  = wbp_pkg::ACC_W;
  localparam int PW  = wbp_pkg::PROD_W;
  localparam int MA  = wbp_pkg::MA_W;
  localparam int MB  = wbp_pkg::MB_W;
  localparam int FW  = wbp_pkg::FRAC_W;
  localparam int SS  = wbp_pkg::SCALE_SHIFT;
  localparam int DFW = wbp_pkg::DIFF_W;
  localparam int SW  = wbp_pkg::SPD_W;
  localparam int UW  = wbp_pkg::DUTY_W;

  localparam logic signed [PW-1:0]  LIM_HI = PW'(2 ** wbp_pkg::DIFF_LOG);
  localparam logic signed [PW-1:0]  LIM_LO = -PW'(2 ** wbp_pkg::DIFF_LOG);
  localparam logic signed [SW-1:0]  SPD_MAX = {{(SW - UW){1'b0}}, wbp_pkg::DUTY_MAX};

  wbp_pkg::back_state_e state;

  logic signed [EW-1:0]   err_r;
  logic [wbp_pkg::DT_W-1:0] dt_r;
  logic signed [IW-1:0]   integral;
  logic signed [EW-1:0]   last_error;
  logic signed [AW-1:0]   acc;
  logic signed [PW-1:0]   prod;
  logic signed [PW-1:0]   hi_prod;
  logic signed [DFW-1:0]  dsat;
  logic [UW-1:0]          left_speed;
  logic [UW-1:0]          right_speed;

  logic signed [MA-1:0]   mul_a;
  logic signed [MB-1:0]   mul_b;
  logic signed [EW:0]     derr;
  logic signed [IW:0]     isum;
  logic signed [IW-1:0]   isat;
  logic signed [PW-1:0]   pmag;
  logic signed [PW-1:0]   diff_full;
  logic signed [DFW-1:0]  diff_sat;
  logic signed [SW-1:0]   d_ext;
  logic signed [SW-1:0]   lnew;
  logic signed [SW-1:0]   rnew;
  logic [UW-1:0]          lsat;
  logic [UW-1:0]          rsat;
  logic [UW-1:0]          left_init_sat;
  logic [UW-1:0]          right_init_sat;

  assign q_pop = (state == wbp_pkg::S_IDLE) && !q_empty;

  always_comb begin
    derr = $signed({err_r[EW-1], err_r}) - $signed({last_error[EW-1], last_error});
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      wbp_pkg::S_P: begin
        mul_a = {{(MA - EW){err_r[EW-1]}}, err_r};
        mul_b = {{(MB - GW){1'b0}}, cfg.kp};
      end
      wbp_pkg::S_I: begin
        mul_a = {{(MA - IW){integral[IW-1]}}, integral};
        mul_b = {{(MB - GW){1'b0}}, cfg.ki};
      end
      wbp_pkg::S_D: begin
        mul_a = {{(MA - EW - 1){derr[EW]}}, derr};
        mul_b = {{(MB - GW){1'b0}}, cfg.kd};
      end
      wbp_pkg::S_HI: begin
        mul_a = {{(MA - AW + SS){acc[AW-1]}}, acc[AW-1:SS]};
        mul_b = {1'b0, cfg.scale};
      end
      wbp_pkg::S_LO: begin
        mul_a = {{(MA - SS){1'b0}}, acc[SS-1:0]};
        mul_b = {1'b0, cfg.scale};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // integrator add, saturated to its own width
  always_comb begin
    isum = $signed({integral[IW-1], integral})
         + $signed({{(IW + 1 - EW - FW){err_r[EW-1]}}, err_r, {FW{1'b0}}});
    if (isum[IW] != isum[IW-1]) begin
      isat = {isum[IW], {(IW - 1){~isum[IW]}}};
    end else begin
      isat = isum[IW-1:0];
    end
  end

  // divider request: magnitude of kd * derr, shifted into Q.8
  always_comb begin
    pmag          = prod[PW-1] ? -prod : prod;
    div_req.start = (state == wbp_pkg::S_DSET);
    div_req.neg   = prod[PW-1];
    div_req.num   = {pmag[wbp_pkg::DMAG_W-1:0], {FW{1'b0}}};
    div_req.den   = dt_r;
  end

  always_comb begin
    diff_full = hi_prod + $signed({{SS{1'b0}}, prod[PW-1:SS]});
    if (diff_full > LIM_HI) begin
      diff_sat = LIM_HI[DFW-1:0];
    end else if (diff_full < LIM_LO) begin
      diff_sat = LIM_LO[DFW-1:0];
    end else begin
      diff_sat = diff_full[DFW-1:0];
    end
  end

  always_comb begin
    d_ext = {{(SW - DFW){dsat[DFW-1]}}, dsat};
    lnew  = $signed({{(SW - UW){1'b0}}, left_speed}) + d_ext;
    rnew  = $signed({{(SW - UW){1'b0}}, right_speed}) - d_ext;
    if (lnew < 0) begin
      lsat = '0;
    end else if (lnew > SPD_MAX) begin
      lsat = wbp_pkg::DUTY_MAX;
    end else begin
      lsat = lnew[UW-1:0];
    end
    if (rnew < 0) begin
      rsat = '0;
    end else if (rnew > SPD_MAX) begin
      rsat = wbp_pkg::DUTY_MAX;
    end else begin
      rsat = rnew[UW-1:0];
    end
    left_init_sat  = (cfg.left_init > wbp_pkg::DUTY_MAX) ? wbp_pkg::DUTY_MAX
                                                         : cfg.left_init;
    right_init_sat = (cfg.right_init > wbp_pkg::DUTY_MAX) ? wbp_pkg::DUTY_MAX
                                                          : cfg.right_init;
  end

  // shared multiplier, registered
  always_ff @(posedge clk) begin
    prod <= PW'(mul_a) * PW'(mul_b);
  end

  // result register: load from the emit step, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == wbp_pkg::S_EMIT) && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= wbp_pkg::S_IDLE;
      integral    <= '0;
      last_error  <= '0;
      left_speed  <= wbp_pkg::LEFT_INIT_RST;
      right_speed <= wbp_pkg::RIGHT_INIT_RST;
    end else begin
      unique case (state)
        wbp_pkg::S_IDLE: begin
          if (!q_empty) begin
            err_r <= q_data.err;
            dt_r  <= q_data.dt;
            if (q_data.prime) begin
              left_speed  <= left_init_sat;
              right_speed <= right_init_sat;
              state       <= wbp_pkg::S_EMIT;
            end else begin
              state <= wbp_pkg::S_P;
            end
          end
        end
        wbp_pkg::S_P: begin
          integral <= isat;
          state    <= wbp_pkg::S_I;
        end
        wbp_pkg::S_I: begin
          // proportional term in Q.8
          acc   <= {prod[AW-FW-1:0], {FW{1'b0}}};
          state <= wbp_pkg::S_D;
        end
        wbp_pkg::S_D: begin
          acc        <= acc + prod[AW-1:0];
          integral   <= integral >>> cfg.decay;
          last_error <= err_r;
          state      <= wbp_pkg::S_DSET;
        end
        wbp_pkg::S_DSET: begin
          state <= wbp_pkg::S_DIV;
        end
        wbp_pkg::S_DIV: begin
          if (div_rsp.done) begin
            acc   <= acc + {{(AW - wbp_pkg::DIV_Q_W){div_rsp.quo[wbp_pkg::DIV_Q_W-1]}},
                            div_rsp.quo};
            state <= wbp_pkg::S_HI;
          end
        end
        wbp_pkg::S_HI: begin
          state <= wbp_pkg::S_LO;
        end
        wbp_pkg::S_LO: begin
          hi_prod <= prod;
          state   <= wbp_pkg::S_SUM;
        end
        wbp_pkg::S_SUM: begin
          dsat  <= diff_sat;
          state <= wbp_pkg::S_DUTY;
        end
        wbp_pkg::S_DUTY: begin
          left_speed  <= lsat;
          right_speed <= rsat;
          state       <= wbp_pkg::S_EMIT;
        end
        wbp_pkg::S_EMIT: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            out_left  <= left_speed;
            out_right <= right_speed;
            out_err   <= err_r;
            state     <= wbp_pkg::S_IDLE;
          end
        end
        default: begin
          state <= wbp_pkg::S_IDLE;
        end
      endcase
    end
  end

endmodule

[src/wheel_balance_pid.sv]
// ----------------------------------------------------------------------------
// wheel_balance_pid: wheel balancing PID controller with leaky integrator
// Ticks are worked on one at a time, through the bit-serial derivative
// divider and five passes through the shared multiplier; a priming tick
// goes straight to the emit step. Up to two further ticks queue while one
// is worked on; one result waits.
// Reset (rst, synchronous) restores register defaults and unprimes the block.
// ----------------------------------------------------------------------------
module wheel_balance_pid (
  input  logic                            clk,
  input  logic                            rst,
  // tdata: left_pulses[31:0], right_pulses[63:32], elapsed_us[83:64]
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [wbp_pkg::IN_W-1:0]        s_axis_tdata,
  // tdata: left_duty[16:0], right_duty[33:17], wheel_error[49:34]
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [wbp_pkg::OUT_W-1:0]       m_axis_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [wbp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wbp_pkg::CFG_DATA_W-1:0]  cfg_data
);

  wbp_pkg::cfg_t      cfg;
  wbp_pkg::q_entry_t  q_wr;
  wbp_pkg::q_entry_t  q_rd;
  wbp_pkg::div_req_t  div_req;
  wbp_pkg::div_rsp_t  div_rsp;
  logic               q_push;
  logic               q_pop;
  logic               q_full;
  logic               q_empty;
  logic [wbp_pkg::DUTY_W-1:0] out_left;
  logic [wbp_pkg::DUTY_W-1:0] out_right;
  logic [wbp_pkg::ERR_W-1:0]  out_err;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kp         <= wbp_pkg::KP_RST;
      cfg.ki         <= wbp_pkg::KI_RST;
      cfg.kd         <= wbp_pkg::KD_RST;
      cfg.decay      <= wbp_pkg::DECAY_RST;
      cfg.scale      <= wbp_pkg::SCALE_RST;
      cfg.left_init  <= wbp_pkg::LEFT_INIT_RST;
      cfg.right_init <= wbp_pkg::RIGHT_INIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        wbp_pkg::REG_KP:         cfg.kp         <= cfg_data[wbp_pkg::GAIN_W-1:0];
        wbp_pkg::REG_KI:         cfg.ki         <= cfg_data[wbp_pkg::GAIN_W-1:0];
        wbp_pkg::REG_KD:         cfg.kd         <= cfg_data[wbp_pkg::GAIN_W-1:0];
        wbp_pkg::REG_DECAY:      cfg.decay      <= cfg_data[wbp_pkg::SHIFT_W-1:0];
        wbp_pkg::REG_SCALE:      cfg.scale      <= cfg_data[wbp_pkg::SCALE_W-1:0];
        wbp_pkg::REG_LEFT_INIT:  cfg.left_init  <= cfg_data[wbp_pkg::DUTY_W-1:0];
        wbp_pkg::REG_RIGHT_INIT: cfg.right_init <= cfg_data[wbp_pkg::DUTY_W-1:0];
        default: begin
          // drop writes to unused indexes
        end
      endcase
    end
  end

  wbp_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_entry       (q_wr)
  );

  wbp_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wr),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_rd),
    .empty   (q_empty)
  );

  wbp_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  wbp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_data    (q_rd),
    .q_pop     (q_pop),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_left  (out_left),
    .out_right (out_right),
    .out_err   (out_err)
  );

  assign m_axis_tdata = {{(wbp_pkg::OUT_W - 2 * wbp_pkg::DUTY_W - wbp_pkg::ERR_W){1'b0}},
                         out_err, out_right, out_left};

  // duties stay within full scale
  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (out_left <= wbp_pkg::DUTY_MAX && out_right <= wbp_pkg::DUTY_MAX))
    else $error("duty above full scale");

  // divider never finishes in the cycle after a start
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    div_req.start |=> !div_rsp.done)
    else $error("divider done right after start");

  // a pop only happens with the divider at rest
  a_pop_div_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (!div_rsp.done && !div_req.start))
    else $error("divider active while a tick is taken");

endmodule

[tb/sv/wbp_duty_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbp_duty_checker: scoreboard for the wheel balance PID
// Follows register writes and encoder ticks, runs a fixed-point model of the
// controller on every accepted tick and compares each returned duty pair and
// wheel error with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module wbp_duty_checker
  import wbp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  tick_valid,
  input  logic                  tick_ready,
  input  logic [IN_W-1:0]       tick_data,
  input  logic                  duty_valid,
  input  logic                  duty_ready,
  input  logic [OUT_W-1:0]      duty_data,
  input  logic                  reg_valid,
  input  logic                  reg_ready,
  input  logic [CFG_IDX_W-1:0]  reg_index,
  input  logic [CFG_DATA_W-1:0] reg_data,
  output int                    failures,
  output int                    pending
);

  localparam int     RES_W     = 2 * DUTY_W + ERR_W;
  localparam longint DUTY_TOP  = 65536;
  localparam longint DIFF_CAP  = 1048576;
  localparam longint INTEG_MAX = (longint'(1) << (INTEGRATOR_WIDTH - 1)) - 1;
  localparam longint INTEG_MIN = -INTEG_MAX - 1;
  localparam int     PRINT_CAP = 30;

  // left duty in the lowest bits, as on the result bus
  typedef struct packed {
    logic [ERR_W-1:0]  err;
    logic [DUTY_W-1:0] right;
    logic [DUTY_W-1:0] left;
  } duty_word_t;

  logic [GAIN_W-1:0]      kp, ki, kd;
  logic [SHIFT_W-1:0]     decay;
  logic [SCALE_W-1:0]     scale;
  logic [DUTY_W-1:0]      left_init, right_init;

  logic [COUNT_WIDTH-1:0] prev_left, prev_right;
  bit                     primed;
  longint                 prev_err, integ, left_speed, right_speed;

  duty_word_t             duty_queue[$];

  function automatic longint clip(longint x, longint lo, longint hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  task automatic report_mismatch(string msg);
    if (failures < PRINT_CAP) $display("[%0t] MISMATCH: %s", $realtime, msg);
    failures++;
  endtask

  task automatic advance_controller(input logic [IN_W-1:0] tick, output duty_word_t want);
    logic [COUNT_WIDTH-1:0] cur_left, cur_right, step_left, step_right;
    longint dt, err, p_term, i_term, d_term, total, hi, lo, diff;
    cur_left  = -tick[FIELD_W-1:0];
    cur_right = tick[2*FIELD_W-1:FIELD_W];
    dt        = longint'(tick[2*FIELD_W+DT_W-1:2*FIELD_W]);
    if (dt == 0) dt = 1;
    err = 0;
    if (!primed) begin
      // first tick: take the counts and load the duties only
      primed      = 1'b1;
      left_speed  = clip(longint'(left_init), 0, DUTY_TOP);
      right_speed = clip(longint'(right_init), 0, DUTY_TOP);
    end else begin
      step_left  = cur_left - prev_left;
      step_right = cur_right - prev_right;
      err = clip(longint'($signed(step_right)) - longint'($signed(step_left)), -32768, 32767);
      p_term = longint'(kp) * err * 256;
      integ  = clip(integ + err * 256, INTEG_MIN, INTEG_MAX);
      i_term = integ * longint'(ki);
      integ  = integ >>> decay;
      d_term = longint'(kd) * (err - prev_err) * 256 / dt;
      prev_err = err;
      total = p_term + d_term + i_term;
      // split the product so it stays inside 64 bits
      hi   = total >>> 24;
      lo   = total & longint'(24'hFFFFFF);
      diff = hi * longint'(scale) + ((lo * longint'(scale)) >>> 24);
      diff = clip(diff, -DIFF_CAP, DIFF_CAP);
      left_speed  = clip(left_speed + diff, 0, DUTY_TOP);
      right_speed = clip(right_speed - diff, 0, DUTY_TOP);
    end
    prev_left  = cur_left;
    prev_right = cur_right;
    want.left  = DUTY_W'(left_speed);
    want.right = DUTY_W'(right_speed);
    want.err   = ERR_W'(err);
  endtask

  always @(posedge clk) begin
    duty_word_t want, got;
    if (rst) begin
      kp          = 16'd1536;
      ki          = 16'd512;
      kd          = 16'd5120;
      decay       = 4'd1;
      scale       = 24'd12945;
      left_init   = 17'd13107;
      right_init  = 17'd10486;
      prev_left   = '0;
      prev_right  = '0;
      primed      = 1'b0;
      prev_err    = 0;
      integ       = 0;
      left_speed  = 13107;
      right_speed = 10486;
      duty_queue.delete();
      pending <= 0;
    end else begin
      if (reg_valid && reg_ready) begin
        case (reg_index)
          REG_KP:         kp         = reg_data[GAIN_W-1:0];
          REG_KI:         ki         = reg_data[GAIN_W-1:0];
          REG_KD:         kd         = reg_data[GAIN_W-1:0];
          REG_DECAY:      decay      = reg_data[SHIFT_W-1:0];
          REG_SCALE:      scale      = reg_data[SCALE_W-1:0];
          REG_LEFT_INIT:  left_init  = reg_data[DUTY_W-1:0];
          REG_RIGHT_INIT: right_init = reg_data[DUTY_W-1:0];
          default: ;
        endcase
      end
      if (duty_valid && duty_ready) begin
        got = duty_word_t'(duty_data[RES_W-1:0]);
        if (duty_queue.size() == 0) begin
          report_mismatch("duty result with no tick waiting");
        end else begin
          want = duty_queue.pop_front();
          if (got.left !== want.left)
            report_mismatch($sformatf("left_duty got %0d expected %0d", got.left, want.left));
          if (got.right !== want.right)
            report_mismatch($sformatf("right_duty got %0d expected %0d",
                                      got.right, want.right));
          if (got.err !== want.err)
            report_mismatch($sformatf("wheel_error got %0d expected %0d",
                                      $signed(got.err), $signed(want.err)));
        end
      end
      if (tick_valid && tick_ready) begin
        advance_controller(tick_data, want);
        duty_queue.push_back(want);
      end
      pending <= duty_queue.size();
    end
  end

endmodule

[tb/sv/tb_wheel_balance_pid.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_wheel_balance_pid: stimulus and verdict for the wheel balance PID
// Programs the gains in phases (defaults, extremes, all zero, random), sends
// a directed set of encoder ticks and then random well-formed motion with
// noise, idling both buses at random; the scoreboard does the checking.
// ----------------------------------------------------------------------------
module tb_wheel_balance_pid;
  import wbp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;  // no register behind it
  localparam int ITEMS_PER_PHASE = 210;
  localparam int RANDOM_PHASES   = 9;
  localparam int IDLE_PCT        = 14;
  localparam int HOLD_CYCLES     = 400;
  localparam int QUIET_LIMIT     = 5000;
  localparam int SETTLE_CYCLES   = 60;

  typedef struct {
    logic [CFG_DATA_W-1:0] kp, ki, kd, decay, scale, left_init, right_init;
  } gain_set_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_W-1:0]       s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_W-1:0]      m_axis_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int                    failures, pending;
  logic                  steady = 1'b0;
  logic                  hold_req = 1'b0;
  logic                  hold_done = 1'b0;
  int                    hold_left = 0;
  int                    quiet = 0;
  logic [FIELD_W-1:0]    raw_left = '0, raw_right = '0;

  always #1 clk = ~clk;

  wheel_balance_pid dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  wbp_duty_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .tick_valid (s_axis_tvalid),
    .tick_ready (s_axis_tready),
    .tick_data  (s_axis_tdata),
    .duty_valid (m_axis_tvalid),
    .duty_ready (m_axis_tready),
    .duty_data  (m_axis_tdata),
    .reg_valid  (cfg_valid),
    .reg_ready  (cfg_ready),
    .reg_index  (cfg_index),
    .reg_data   (cfg_data),
    .failures   (failures),
    .pending    (pending)
  );

  // result side: random stalls, one long hold-off while ticks keep coming
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      m_axis_tready <= 1'b0;
      hold_left     <= HOLD_CYCLES;
      hold_done     <= 1'b1;
    end else begin
      m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic program_gains(gain_set_t g, bit stray);
    put_reg(REG_KP, g.kp);
    put_reg(REG_KI, g.ki);
    put_reg(REG_KD, g.kd);
    put_reg(REG_DECAY, g.decay);
    put_reg(REG_SCALE, g.scale);
    put_reg(REG_LEFT_INIT, g.left_init);
    put_reg(REG_RIGHT_INIT, g.right_init);
    if (stray) put_reg(REG_NONE, CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic send_counts(logic [FIELD_W-1:0] left, logic [FIELD_W-1:0] right,
                             logic [DT_W-1:0] dt);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    raw_left  = left;
    raw_right = right;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_W'({dt, right, left});
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // mostly balanced motion; the rest jumps, noise and errors near saturation
  task automatic next_tick();
    int                 pick, dt_pick;
    logic [FIELD_W-1:0] dl, dr, nl, nr;
    logic [DT_W-1:0]    dt;
    pick = $urandom_range(99);
    dl = $urandom_range(0, 600) - 300;
    dr = dl + $urandom_range(0, 40) - 20;
    nl = raw_left - dl;
    nr = raw_right + dr;
    if (pick >= 70 && pick < 80) begin
      nl = raw_left - ($urandom_range(0, 400000) - 200000);
      nr = raw_right + ($urandom_range(0, 400000) - 200000);
    end else if (pick >= 80 && pick < 88) begin
      nl = $urandom;
      nr = $urandom;
    end else if (pick >= 88 && pick < 95) begin
      dr = dl + ($urandom_range(1) ? 32'd32760 : -32'd32775) + $urandom_range(0, 15);
      nr = raw_right + dr;
    end
    dt_pick = $urandom_range(99);
    if (dt_pick < 5)       dt = '0;
    else if (dt_pick < 10) dt = DT_W'($urandom);
    else                   dt = DT_W'($urandom_range(1, 12000));
    send_counts(nl, nr, dt);
  endtask

  function automatic gain_set_t random_gains();
    gain_set_t g;
    g.kp    = CFG_DATA_W'(($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 4000));
    g.ki    = CFG_DATA_W'(($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 2000));
    g.kd    = CFG_DATA_W'(($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 8000));
    g.decay = CFG_DATA_W'(($urandom_range(4) == 0) ? $urandom : $urandom_range(0, 15));
    g.scale = CFG_DATA_W'(($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 40000));
    g.left_init  = CFG_DATA_W'($urandom);
    g.right_init = CFG_DATA_W'($urandom);
    return g;
  endfunction

  // hold the tick side low until every result is back, then let the block settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    gain_set_t g;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // init duties at both ends: left beyond full scale, right at zero
    g = '{kp: 1536, ki: 512, kd: 5120, decay: 1, scale: 12945,
          left_init: 24'hFFFFFF, right_init: 0};
    program_gains(g, 1'b1);

    send_counts(32'h8000_0000, 32'h7FFF_FFFF, 20'd0);   // priming, no elapsed time
    send_counts(raw_left, raw_right, 20'd1);
    send_counts(raw_left - 32'd100, raw_right + 32'd100, 20'd1000);   // both wrap
    send_counts(raw_left - 32'd50, raw_right + 32'd80, 20'd1000);
    send_counts(raw_left, raw_right + 32'h0010_0000, 20'hFFFFF);
    send_counts(raw_left - 32'h0010_0000, raw_right, 20'd0);
    send_counts(raw_left, raw_right + 32'd32767, 20'd500);
    send_counts(raw_left - 32'd32768, raw_right, 20'd500);
    send_counts(raw_left - 32'd32769, raw_right, 20'd500);
    send_counts(32'h0000_0000, 32'h0000_0000, 20'd1);
    send_counts(32'hFFFF_FFFF, 32'hFFFF_FFFF, 20'h80000);
    send_counts(32'h7FFF_FFFF, 32'h8000_0000, 20'h7FFFF);
    send_counts(32'h5555_5555, 32'hAAAA_AAAA, 20'h55555);
    send_counts(32'hAAAA_AAAA, 32'h5555_5555, 20'hAAAAA);
    for (int k = 0; k < 8; k++)
      send_counts(raw_left - 32'd300, raw_right + (k[0] ? 32'd500 : 32'd100), 20'd2000);
    drain();

    for (int ph = 1; ph <= RANDOM_PHASES; ph++) begin
      case (ph)
        1: g = '{kp: 1536, ki: 512, kd: 5120, decay: 1, scale: 12945,
                 left_init: 13107, right_init: 10486};
        // top of every range, spare data bits set as well
        2: g = '{kp: 24'hFFFFFF, ki: 24'hFFFFFF, kd: 24'hFFFFFF, decay: 24'hFFFFFF,
                 scale: 24'hFFFFFF, left_init: 24'h010000, right_init: 24'h01FFFF};
        3: g = '{kp: 0, ki: 0, kd: 0, decay: 0, scale: 0, left_init: 0, right_init: 0};
        default: g = random_gains();
      endcase
      steady   <= (ph == 1);
      hold_req <= (ph == 2);
      program_gains(g, ph == 5);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) next_tick();
      drain();
    end

    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[filelist.f]
src/wbp_pkg.sv
src/wbp_front.sv
src/wbp_fifo.sv
src/wbp_div.sv
src/wbp_back.sv
src/wheel_balance_pid.sv
tb/sv/wbp_duty_checker.sv
tb/sv/tb_wheel_balance_pid.sv
